// ===== src/layered_fog_haze_unit_defines.svh =====
// Assertion macros for the checker file
`ifndef LAYERED_FOG_HAZE_UNIT_DEFINES_SVH
`define LAYERED_FOG_HAZE_UNIT_DEFINES_SVH
// Assert that an antecedent implies a consequent in the next cycle
`define LFH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
// Assert that an antecedent implies a consequent in the same cycle
`define LFH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`endif

// ===== src/lfh_pkg.sv =====
// Shared constants and types for the layered fog haze unit
`timescale 1ns / 1ps
package lfh_pkg;
   localparam int MAX_BANDS = 16;
   localparam int IDX_W = $clog2(MAX_BANDS);
   localparam int DEPTH = 2 * MAX_BANDS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(MAX_BANDS + 1);
   localparam logic [16:0] HAZE_ONE = 17'h10000;

   localparam logic [2:0] REG_FOG_START = 3'd0;
   localparam logic [2:0] REG_VISIBLE   = 3'd1;
   localparam logic [2:0] REG_SCALE     = 3'd2;
   localparam logic [2:0] REG_UP_CNT    = 3'd3;
   localparam logic [2:0] REG_DOWN_CNT  = 3'd4;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Classified work for the back end
   typedef struct packed {
      logic                is_load;
      logic [ADDR_W-1:0]   addr;
      logic [31:0]         height;
      logic [31:0]         density;
      logic                is_fog;
      logic [31:0]         ray_dist;
      logic [31:0]         ht;
      logic                down;
   } cmd_type;

   localparam int QDEPTH = 2;
endpackage

// ===== src/lfh_front.sv =====
// Front end: accepts transactions, classifies them and queues them
`timescale 1ns / 1ps
module lfh_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_op,
   input  logic             req_direction,
   input  logic [3:0]       req_band_index,
   input  logic [31:0]      req_band_height,
   input  logic [31:0]      req_band_density,
   input  logic             req_band_is_fog,
   input  logic [31:0]      req_ray_distance,
   input  logic [31:0]      req_ray_height_delta,
   output logic             q_valid,
   output lfh_pkg::cmd_type q_cmd,
   input  logic             q_pop
);
   import lfh_pkg::*;

   cmd_type     slot_ff [QDEPTH];
   logic        wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push, drop;
   cmd_type     c;

   always_comb begin
      c = '0;
      c.is_load  = (req_op == OP_LOAD);
      c.addr     = {req_direction, req_band_index[IDX_W-1:0]};
      c.height   = req_band_height;
      c.density  = req_band_density;
      c.is_fog   = req_band_is_fog;
      c.ray_dist = req_ray_distance;
      c.down     = req_ray_height_delta[31];
      c.ht       = req_ray_height_delta[31] ? (~req_ray_height_delta + 32'd1)
                                            : req_ray_height_delta;
   end

   assign req_stall = (cnt_ff == 2'(QDEPTH));
   // drop loads whose index is past the table
   assign drop  = (req_op == OP_LOAD) && ({1'b0, req_band_index} >= 5'(MAX_BANDS));
   assign push  = req_valid && !req_stall && !drop;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_cmd   = slot_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = q_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wp_ff] <= c;
   end
endmodule

// ===== src/lfh_divider.sv =====
// Restoring serial divider, 64 by 32 bits, one quotient bit a cycle
`timescale 1ns / 1ps
module lfh_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   import lfh_pkg::*;

   logic [63:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [31:0] dv_ff, dv_in;
   logic [6:0]  n_ff, n_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; dv_in = dv_ff; n_in = n_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[31:0], q_ff[63]};
      if (start) begin
         q_in = dividend; r_in = '0; dv_in = divisor; n_in = 7'd64; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dv_ff}) begin
            r_in = trial - {1'b0, dv_ff};
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[62:0], 1'b0};
         end
         n_in = n_ff - 7'd1;
         if (n_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff <= q_in; r_ff <= r_in; dv_ff <= dv_in; n_ff <= n_in;
   end

   assign done = done_ff;
   assign quotient = q_ff;
endmodule

// ===== src/lfh_back.sv =====
// Back end: band table writes and the haze walk for queries
`timescale 1ns / 1ps
module lfh_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  lfh_pkg::cmd_type q_cmd,
   output logic             q_pop,
   input  logic [31:0]      fog_start,
   input  logic [31:0]      visible,
   input  logic [31:0]      scale,
   input  logic [4:0]       up_count,
   input  logic [4:0]       down_count,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [16:0]      rsp_haze
);
   import lfh_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_DMUL  = 11'b00000000010,
      S_DSQ   = 11'b00000000100,
      S_DFIN  = 11'b00000001000,
      S_RD    = 11'b00000010000,
      S_TEST  = 11'b00000100000,
      S_DIV   = 11'b00001000000,
      S_WAITD = 11'b00010000000,
      S_MUL   = 11'b00100000000,
      S_ADD   = 11'b01000000000,
      S_OUT   = 11'b10000000000
   } state_type;

   logic [31:0] h_mem [DEPTH];
   logic [31:0] d_mem [DEPTH];
   logic        f_mem [DEPTH];

   state_type   st_ff, st_in;
   cmd_type     cmd_ff, cmd_in;
   logic [31:0] dist_ff, dist_in, ht_ff, ht_in;
   logic [16:0] haze_ff, haze_in;
   logic [63:0] prod_ff, prod_in;
   logic [CNT_W-1:0] i_ff, i_in, cnt_ff, cnt_in;
   logic [31:0] cap_ff, dens_ff, sub_ff, sub_in;
   logic        fog_ff, last_ff, last_in;
   logic        out_v_ff, out_v_in;
   logic [16:0] out_ff, out_in;
   logic [ADDR_W-1:0] raddr;
   logic        div_start, div_done;
   logic [63:0] div_q;
   logic [31:0] dd;
   logic [17:0] tcl;
   logic [16:0] dmag;
   logic [33:0] dsq;
   logic [4:0]  cnt_raw;
   logic [17:0] sum;

   lfh_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(prod_ff), .divisor(ht_ff),
      .done(div_done), .quotient(div_q)
   );

   assign raddr = {cmd_ff.down, i_ff[IDX_W-1:0]};
   assign q_pop = (st_ff == S_IDLE) && q_valid;
   assign rsp_valid = out_v_ff;
   assign rsp_haze  = out_ff;

   always_comb begin
      st_in = st_ff; cmd_in = cmd_ff; dist_in = dist_ff; ht_in = ht_ff;
      haze_in = haze_ff; prod_in = prod_ff; i_in = i_ff; cnt_in = cnt_ff;
      sub_in = sub_ff; last_in = last_ff; div_start = 1'b0;
      out_v_in = out_v_ff && rsp_stall; out_in = out_ff;
      dd = dist_ff - fog_start;
      tcl = (prod_ff[63:16] > 48'h20000) ? 18'h20000 : prod_ff[33:16];
      // distance from 1.0 of the clamped scaled distance
      dmag = (tcl >= {1'b0, HAZE_ONE}) ? 17'(tcl - {1'b0, HAZE_ONE})
                                       : 17'({1'b0, HAZE_ONE} - tcl);
      dsq = {17'd0, dmag} * {17'd0, dmag};
      cnt_raw = cmd_ff.down ? down_count : up_count;
      sum = {1'b0, haze_ff} + {1'b0, prod_ff[40:24]};
      case (st_ff)
         S_IDLE: if (q_valid) begin
            cmd_in = q_cmd;
            if (!q_cmd.is_load) begin
               dist_in = q_cmd.ray_dist;
               ht_in = q_cmd.ht;
               st_in = S_DMUL;
            end
         end
         S_DMUL: begin
            i_in = '0;
            haze_in = '0;
            cnt_in = (cnt_raw > 5'(MAX_BANDS)) ? CNT_W'(MAX_BANDS) : CNT_W'(cnt_raw);
            prod_in = {32'd0, dd} * {32'd0, scale};
            if (dist_ff > fog_start && dist_ff > visible) begin
               haze_in = HAZE_ONE;
               st_in = S_OUT;
            end else if (dist_ff <= fog_start) begin
               st_in = S_RD;
            end else begin
               st_in = S_DSQ;
            end
         end
         S_DSQ: begin
            prod_in = {30'd0, dsq};
            st_in = S_DFIN;
         end
         S_DFIN: begin
            haze_in = HAZE_ONE - prod_ff[32:16];
            st_in = S_RD;
         end
         S_RD: st_in = (i_ff >= cnt_ff) ? S_OUT : S_TEST;
         S_TEST: begin
            if (ht_ff < cap_ff) begin
               prod_in = {32'd0, dist_ff} * {32'd0, dens_ff};
               last_in = 1'b1;
               st_in = fog_ff ? S_ADD : S_OUT;
            end else if (ht_ff == 32'd0) begin
               sub_in = '0;
               last_in = 1'b0;
               st_in = S_MUL;
            end else begin
               prod_in = {32'd0, dist_ff} * {32'd0, cap_ff};
               last_in = 1'b0;
               st_in = S_DIV;
            end
         end
         S_DIV: begin
            div_start = 1'b1;
            st_in = S_WAITD;
         end
         S_WAITD: if (div_done) begin
            sub_in = div_q[31:0];
            st_in = S_MUL;
         end
         S_MUL: begin
            prod_in = {32'd0, sub_ff} * {32'd0, dens_ff};
            dist_in = dist_ff - sub_ff;
            ht_in = ht_ff - cap_ff;
            i_in = i_ff + 1'b1;
            st_in = fog_ff ? S_ADD : S_RD;
         end
         S_ADD: begin
            if (prod_ff[63:41] != '0 || sum > {1'b0, HAZE_ONE}) haze_in = HAZE_ONE;
            else haze_in = sum[16:0];
            st_in = last_ff ? S_OUT : S_RD;
         end
         S_OUT: if (!out_v_ff || !rsp_stall) begin
            out_v_in = 1'b1;
            out_in = haze_ff;
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         out_v_ff <= out_v_in;
      end
      cmd_ff <= cmd_in; dist_ff <= dist_in; ht_ff <= ht_in; haze_ff <= haze_in;
      prod_ff <= prod_in; i_ff <= i_in; cnt_ff <= cnt_in; sub_ff <= sub_in;
      last_ff <= last_in; out_ff <= out_in;
      cap_ff <= h_mem[raddr];
      dens_ff <= d_mem[raddr];
      fog_ff <= f_mem[raddr];
      if (st_ff == S_IDLE && q_valid && q_cmd.is_load) begin
         h_mem[q_cmd.addr] <= q_cmd.height;
         d_mem[q_cmd.addr] <= q_cmd.density;
         f_mem[q_cmd.addr] <= q_cmd.is_fog;
      end
   end
endmodule

// ===== src/layered_fog_haze_unit.sv =====
// Top level of the layered fog haze unit
`timescale 1ns / 1ps
// A query computes distance haze and then, for each band that the ray crosses with
// nonzero height left, runs the one-bit-a-cycle 64-bit divider that splits the ray
// over the band. A two-entry queue sits between the accepting front end and the back
// end; the result register holds a finished value while the next item runs.
module layered_fog_haze_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic        req_direction,
   input  logic [3:0]  req_band_index,
   input  logic [31:0] req_band_height,
   input  logic [31:0] req_band_density,
   input  logic        req_band_is_fog,
   input  logic [31:0] req_ray_distance,
   input  logic [31:0] req_ray_height_delta,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [16:0] rsp_haze,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import lfh_pkg::*;

   logic [31:0] start_ff, vis_ff, scale_ff;
   logic [4:0]  up_ff, down_ff;
   logic        q_valid, q_pop;
   cmd_type     q_cmd;
   logic [2:0]  ridx;

   assign pready = 1'b1;
   assign ridx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0; vis_ff <= '0; scale_ff <= '0; up_ff <= '0; down_ff <= '0;
      end else if (psel && penable && pwrite) begin
         case (ridx)
            REG_FOG_START: start_ff <= pwdata;
            REG_VISIBLE:   vis_ff <= pwdata;
            REG_SCALE:     scale_ff <= pwdata;
            REG_UP_CNT:    up_ff <= pwdata[4:0];
            REG_DOWN_CNT:  down_ff <= pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ridx)
         REG_FOG_START: prdata = start_ff;
         REG_VISIBLE:   prdata = vis_ff;
         REG_SCALE:     prdata = scale_ff;
         REG_UP_CNT:    prdata = {27'd0, up_ff};
         REG_DOWN_CNT:  prdata = {27'd0, down_ff};
         default:       prdata = '0;
      endcase
   end

   lfh_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_op, .req_direction,
      .req_band_index, .req_band_height, .req_band_density, .req_band_is_fog,
      .req_ray_distance, .req_ray_height_delta,
      .q_valid, .q_cmd, .q_pop
   );

   lfh_back u_back (
      .clock, .reset, .q_valid, .q_cmd, .q_pop,
      .fog_start(start_ff), .visible(vis_ff), .scale(scale_ff),
      .up_count(up_ff), .down_count(down_ff),
      .rsp_valid, .rsp_stall, .rsp_haze
   );
endmodule

// ===== src/lfh_checker.sv =====
// Port-level checker for the layered fog haze unit
`timescale 1ns / 1ps
`include "layered_fog_haze_unit_defines.svh"
module lfh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [16:0] rsp_haze,
   input logic        pready
);
   `LFH_ASSERT_NOW(a_haze_max, clock, reset, rsp_valid, rsp_haze <= 17'h10000, "haze above one")
   `LFH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_haze), "held")
   `LFH_ASSERT_NOW(a_pready, clock, reset, 1'b1, pready, "pready low")
   `LFH_ASSERT_NOW(a_stall_known, clock, reset, req_valid, !$isunknown(req_stall), "stall unknown")
endmodule

bind layered_fog_haze_unit lfh_checker u_chk (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_haze, .pready
);

// ===== verif/layered_fog_haze_unit_tb.sv =====
// Self-checking testbench for the layered fog haze unit
`timescale 1ns / 1ps
module layered_fog_haze_unit_tb;
   import lfh_pkg::*;

   localparam int DRAIN_CYCLES = 1300;
   localparam int STALL_LIMIT = 20000;

   class haze_scoreboard;
      bit [31:0] fog_start, visible, scale;
      bit [4:0] up_cnt, down_cnt;
      bit [31:0] height_mem [DEPTH];
      bit [31:0] density_mem [DEPTH];
      bit fog_mem [DEPTH];
      bit [16:0] expected_haze [$];
      int errors;

      function void set_reg(logic [2:0] idx, bit [31:0] val);
         case (idx)
            REG_FOG_START: fog_start = val;
            REG_VISIBLE:   visible = val;
            REG_SCALE:     scale = val;
            REG_UP_CNT:    up_cnt = val[4:0];
            REG_DOWN_CNT:  down_cnt = val[4:0];
            default: ;
         endcase
      endfunction

      function bit [16:0] haze_of(bit [31:0] d, bit [31:0] dz);
         longint unsigned hz, t, sq;
         longint df;
         bit [31:0] ht, cap, sub;
         int base, cnt;
         if (d > fog_start && d > visible) return HAZE_ONE;
         hz = 0;
         if (d > fog_start) begin
            t = (64'(d - fog_start) * 64'(scale)) >> 16;
            if (t > 2 * 65536) t = 2 * 65536;
            df = longint'(t) - 65536;
            sq = longint'(df * df) >> 16;
            hz = 65536 - sq;
         end
         if (dz[31]) begin
            ht = ~dz + 32'd1;
            base = MAX_BANDS;
            cnt = down_cnt;
         end else begin
            ht = dz;
            base = 0;
            cnt = up_cnt;
         end
         if (cnt > MAX_BANDS) cnt = MAX_BANDS;
         for (int i = 0; i < cnt; i++) begin
            cap = height_mem[base + i];
            if (ht < cap) begin
               if (fog_mem[base + i])
                  hz += (64'(d) * 64'(density_mem[base + i])) >> 24;
               if (hz > 65536) hz = 65536;
               break;
            end
            sub = (ht == 0) ? 32'd0 : 32'((64'(d) * 64'(cap)) / 64'(ht));
            if (fog_mem[base + i])
               hz += (64'(sub) * 64'(density_mem[base + i])) >> 24;
            if (hz > 65536) hz = 65536;
            d -= sub;
            ht -= cap;
         end
         return 17'(hz);
      endfunction

      function void note_item(bit op, bit dir, bit [3:0] idx, bit [31:0] h, bit [31:0] den,
                              bit fog, bit [31:0] d, bit [31:0] dz);
         int k;
         if (op == OP_LOAD) begin
            k = dir * MAX_BANDS + idx;
            height_mem[k] = h;
            density_mem[k] = den;
            fog_mem[k] = fog;
         end else begin
            expected_haze = {expected_haze, haze_of(d, dz)};
         end
      endfunction

      function void check_result(bit [16:0] got);
         bit [16:0] want;
         if (expected_haze.size() == 0) begin
            $display("%0t: unexpected result haze=%h", $time, got);
            errors++;
            return;
         end
         want = expected_haze.pop_front();
         if (got !== want) begin
            $display("%0t: haze mismatch expected=%h actual=%h", $time, want, got);
            errors++;
         end
      endfunction

      function int pending();
         return expected_haze.size();
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic req_op = 0, req_direction = 0, req_band_is_fog = 0;
   logic [3:0] req_band_index = 0;
   logic [31:0] req_band_height = 0, req_band_density = 0;
   logic [31:0] req_ray_distance = 0, req_ray_height_delta = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [16:0] rsp_haze;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [4:0] paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic pready;

   haze_scoreboard sb = new();
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit hold_rsp = 0;
   int quiet_cycles = 0;

   layered_fog_haze_unit uut (.*);

   always #10 clock = ~clock;

   // results and receiver back-pressure
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_haze);
         rsp_stall <= hold_rsp || ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("** layered_fog_haze_unit: FAILED **");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] idx, bit [31:0] val);
      @(posedge clock);
      psel <= 1;
      pwrite <= 1;
      penable <= 0;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      sb.set_reg(idx, val);
   endtask

   task automatic send_item(bit op, bit dir, bit [3:0] idx, bit [31:0] h, bit [31:0] den,
                            bit fog, bit [31:0] d, bit [31:0] dz);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_op <= op;
      req_direction <= dir;
      req_band_index <= idx;
      req_band_height <= h;
      req_band_density <= den;
      req_band_is_fog <= fog;
      req_ray_distance <= d;
      req_ray_height_delta <= dz;
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      sb.note_item(op, dir, idx, h, den, fog, d, dz);
   endtask

   task automatic finish_sending();
      req_valid <= 0;
      @(posedge clock);
   endtask

   function automatic bit [31:0] pick_height();
      case ($urandom_range(9))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom();
         default: return $urandom_range(0, 32'h0010_0000);
      endcase
   endfunction

   function automatic bit [31:0] pick_density();
      case ($urandom_range(7))
         0: return 32'd0;
         1: return $urandom();
         default: return $urandom_range(0, 32'h0040_0000);
      endcase
   endfunction

   task automatic send_load();
      send_item(OP_LOAD, 1'($urandom_range(1)), 4'($urandom_range(15)), pick_height(),
                pick_density(), 1'($urandom_range(1)), $urandom(), $urandom());
   endtask

   task automatic send_query();
      bit [31:0] d, dz;
      case ($urandom_range(9))
         0: d = $urandom();
         1: d = sb.visible;
         default: d = $urandom_range(0, sb.visible);
      endcase
      case ($urandom_range(11))
         0: dz = 32'h8000_0000;
         1: dz = 32'h7FFF_FFFF;
         2: dz = $urandom();
         3: dz = 0;
         default: begin
            dz = $urandom_range(0, 32'h0040_0000);
            if ($urandom_range(1)) dz = ~dz + 32'd1;
         end
      endcase
      send_item(OP_QUERY, 1'($urandom_range(1)), 4'($urandom_range(15)), $urandom(),
                $urandom(), 1'($urandom_range(1)), d, dz);
   endtask

   task automatic drain();
      finish_sending();
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_config(int kind);
      bit [31:0] s, v, span;
      case (kind)
         0: begin
            s = 0; v = 0;
         end
         1: begin
            s = 32'hFFFF_FFFF; v = 32'hFFFF_FFFF;
         end
         default: begin
            s = $urandom_range(0, 32'h0010_0000);
            v = s + $urandom_range(1, 32'h0100_0000);
         end
      endcase
      span = v - s;
      write_reg(REG_FOG_START, s);
      write_reg(REG_VISIBLE, v);
      if (kind == 1) write_reg(REG_SCALE, 32'hFFFF_FFFF);
      else if (kind == 0 || $urandom_range(5) == 0) write_reg(REG_SCALE, $urandom());
      else write_reg(REG_SCALE, 32'((64'd1 << 32) / (span == 0 ? 64'd1 : 64'(span))));
      if (kind == 1) begin
         write_reg(REG_UP_CNT, 32'd31);
         write_reg(REG_DOWN_CNT, 32'd16);
      end else if (kind == 0) begin
         write_reg(REG_UP_CNT, 32'd0);
         write_reg(REG_DOWN_CNT, 32'd17);
      end else begin
         write_reg(REG_UP_CNT, $urandom_range(0, 5));
         write_reg(REG_DOWN_CNT, $urandom_range(0, 5));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      write_reg(REG_FOG_START, 32'h0001_0000);
      write_reg(REG_VISIBLE, 32'h0010_0000);
      write_reg(REG_SCALE, 32'h0000_1111);
      write_reg(REG_UP_CNT, 32'd4);
      write_reg(REG_DOWN_CNT, 32'd4);

      // fill both tables so no query reads an empty entry
      for (int k = 0; k < DEPTH; k++)
         send_item(OP_LOAD, 1'(k / MAX_BANDS), 4'(k % MAX_BANDS),
                   $urandom_range(0, 32'h0004_0000),
                   $urandom_range(0, 32'h0100_0000), k[0], 0, 0);

      send_item(OP_LOAD, 0, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0);
      send_item(OP_LOAD, 1, 4'd0, 32'd0, 32'd0, 0, 0, 0);
      send_item(OP_LOAD, 0, 4'd0, 32'd0, 32'h0100_0000, 1, 0, 0);
      send_item(OP_QUERY, 0, 0, 0, 0, 0, 32'd0, 32'd0);
      send_item(OP_QUERY, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'd0);
      send_item(OP_QUERY, 0, 0, 0, 0, 0, 32'h0010_0000, 32'd0);
      send_item(OP_QUERY, 0, 0, 0, 0, 0, 32'h0001_0000, 32'h0000_8000);
      send_item(OP_QUERY, 0, 0, 0, 0, 0, 32'h0008_0000, 32'h8000_0000);
      send_item(OP_QUERY, 0, 0, 0, 0, 0, 32'h0008_0000, 32'h7FFF_FFFF);
      send_item(OP_QUERY, 0, 0, 0, 0, 0, 32'h000F_FFFF, 32'hFFFF_0000);
      send_item(OP_QUERY, 0, 0, 0, 0, 0, 32'h0001_0001, 32'h0002_0000);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         random_config(ph);
         case (ph % 4)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 53; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 53; end
            default: begin send_idle_pct = 25; stall_pct = 25; end
         endcase
         for (int n = 0; n < 135; n++) begin
            if ($urandom_range(99) < 40) send_load();
            else send_query();
         end
         if (ph == 3) begin
            // hold the result side while requests keep coming, then pause until empty
            fork
               begin
                  hold_rsp = 1;
                  repeat (3000) @(posedge clock);
                  hold_rsp = 0;
               end
               for (int n = 0; n < 12; n++) send_query();
            join
         end
         drain();
      end

      if (sb.errors == 0)
         $display("** layered_fog_haze_unit: PASSED **");
      else
         $display("** layered_fog_haze_unit: FAILED **");
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+src
src/lfh_pkg.sv
src/lfh_front.sv
src/lfh_divider.sv
src/lfh_back.sv
src/layered_fog_haze_unit.sv
src/lfh_checker.sv
verif/layered_fog_haze_unit_tb.sv
